FILE: src/plane_from_three_points_macros.svh
// Assertion macros for the plane-from-three-points block.
// Used by the top level; no other dependencies.
`ifndef PLANE_FROM_THREE_POINTS_MACROS_SVH
`define PLANE_FROM_THREE_POINTS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define PFP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under an active-low reset.
`define PFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define PFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/pfp_pkg.sv
// Shared types and pipeline constants for the plane-from-three-points block.
// No dependencies.
package pfp_pkg;

    typedef struct packed {
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_a_z;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_b_z;
        logic signed [31:0] point_c_x;
        logic signed [31:0] point_c_y;
        logic signed [31:0] point_c_z;
    } t_points;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] offset;
        logic               degenerate;
    } t_plane;

    // exact cross product components
    typedef struct packed {
        logic signed [65:0] cx;
        logic signed [65:0] cy;
        logic signed [65:0] cz;
    } t_cross;

    // rescaled component: sign and 31-bit magnitude
    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_comp;

    localparam int LAT_CROSS  = 3;
    localparam int LAT_SCALE  = 5;
    localparam int SQ_ITER    = 32;
    localparam int SQ_PER     = 2;
    localparam int LAT_SQRT   = SQ_ITER / SQ_PER;
    localparam int DIV_ITER   = 31;
    localparam int DIV_PER    = 2;
    localparam int LAT_DIV    = (DIV_ITER + DIV_PER - 1) / DIV_PER;
    localparam int LAT_OFS    = 4;
    localparam int LAT_FRONT  = LAT_CROSS + LAT_SCALE + LAT_SQRT + LAT_DIV;
    localparam int LAT_TOTAL  = LAT_FRONT + LAT_OFS;

endpackage

FILE: src/pfp_cross.sv
// Edge differences and exact cross product, three register stages.
// Depends on pfp_pkg.
module pfp_cross import pfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_points i_pts,
    output logic    o_vld,
    output t_cross  o_cross
);
    logic [LAT_CROSS-1:0] r_vld;
    logic signed [32:0] r_ux, r_uy, r_uz, r_wx, r_wy, r_wz;
    logic signed [65:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    t_cross r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_CROSS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux <= 33'(i_pts.point_b_x) - 33'(i_pts.point_a_x);
        r_uy <= 33'(i_pts.point_b_y) - 33'(i_pts.point_a_y);
        r_uz <= 33'(i_pts.point_b_z) - 33'(i_pts.point_a_z);
        r_wx <= 33'(i_pts.point_c_x) - 33'(i_pts.point_a_x);
        r_wy <= 33'(i_pts.point_c_y) - 33'(i_pts.point_a_y);
        r_wz <= 33'(i_pts.point_c_z) - 33'(i_pts.point_a_z);
        r_p0 <= r_uy * r_wz;
        r_p1 <= r_uz * r_wy;
        r_p2 <= r_uz * r_wx;
        r_p3 <= r_ux * r_wz;
        r_p4 <= r_ux * r_wy;
        r_p5 <= r_uy * r_wx;
        r_cross.cx <= r_p0 - r_p1;
        r_cross.cy <= r_p2 - r_p3;
        r_cross.cz <= r_p4 - r_p5;
    end

    assign o_vld   = r_vld[LAT_CROSS-1];
    assign o_cross = r_cross;
endmodule

FILE: src/pfp_scale.sv
// Common rescale of the cross product and its squared length, five stages.
// Depends on pfp_pkg.
module pfp_scale import pfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_cross      i_cross,
    output logic        o_vld,
    output t_comp       o_comp [3],
    output logic [63:0] o_q,
    output logic        o_deg
);
    logic [LAT_SCALE-1:0] r_vld;
    logic [64:0] r1_mag [3];
    logic        r1_neg [3];
    logic [64:0] r2_mag [3];
    logic        r2_neg [3];
    logic [6:0]  r2_lmax;
    t_comp       r3_comp [3];
    logic        r3_deg;
    t_comp       r4_comp [3];
    logic [61:0] r4_sq [3];
    logic        r4_deg;
    t_comp       r5_comp [3];
    logic [63:0] r5_q;
    logic        r5_deg;

    logic signed [65:0] cin [3];
    logic [64:0] orv;
    logic [6:0]  lmax;
    logic [6:0]  rsh;
    logic [6:0]  lsh;

    assign cin[0] = i_cross.cx;
    assign cin[1] = i_cross.cy;
    assign cin[2] = i_cross.cz;

    always_comb begin
        orv  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        lmax = '0;
        for (int i = 0; i < 65; i++) begin
            if (orv[i]) lmax = 7'(i + 1);
        end
    end

    always_comb begin
        if (r2_lmax > 7'd31) begin
            rsh = r2_lmax - 7'd31;
            lsh = '0;
        end else begin
            rsh = '0;
            lsh = 7'd31 - r2_lmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_SCALE-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_neg[i]      <= cin[i][65];
            r1_mag[i]      <= 65'(cin[i][65] ? -cin[i] : cin[i]);
            r2_neg[i]      <= r1_neg[i];
            r2_mag[i]      <= r1_mag[i];
            r3_comp[i].neg <= r2_neg[i];
            r3_comp[i].mag <= 31'((r2_mag[i] >> rsh) << lsh);
            r4_comp[i]     <= r3_comp[i];
            r4_sq[i]       <= r3_comp[i].mag * r3_comp[i].mag;
            r5_comp[i]     <= r4_comp[i];
        end
        r2_lmax <= lmax;
        r3_deg  <= (r2_lmax == 7'd0);
        r4_deg  <= r3_deg;
        r5_q    <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
        r5_deg  <= r4_deg;
    end

    assign o_vld  = r_vld[LAT_SCALE-1];
    assign o_comp = r5_comp;
    assign o_q    = r5_q;
    assign o_deg  = r5_deg;
endmodule

FILE: src/pfp_isqrt.sv
// Pipelined integer square root of a 64-bit value, two bit pairs per stage.
// Depends on pfp_pkg.
module pfp_isqrt import pfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_val,
    output logic        o_vld,
    output logic [31:0] o_root
);
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    function automatic t_sq sq_step(t_sq s, logic [63:0] bitv);
        logic [64:0] trial;
        t_sq r;
        trial = {1'b0, s.res} + {1'b0, bitv};
        if ({1'b0, s.v} >= trial) begin
            r.v   = s.v - trial[63:0];
            r.res = (s.res >> 1) + bitv;
        end else begin
            r.v   = s.v;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    logic [LAT_SQRT-1:0] r_vld;
    t_sq r_s [LAT_SQRT];
    t_sq n_s [LAT_SQRT];

    for (genvar g = 0; g < LAT_SQRT; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_comb begin
                n_s[g] = '{v: i_val, res: 64'd0};
                for (int j = 0; j < SQ_PER; j++) begin
                    n_s[g] = sq_step(n_s[g], 64'd1 << (62 - 2 * (g * SQ_PER + j)));
                end
            end
        end else begin : g_rest
            always_comb begin
                n_s[g] = r_s[g-1];
                for (int j = 0; j < SQ_PER; j++) begin
                    n_s[g] = sq_step(n_s[g], 64'd1 << (62 - 2 * (g * SQ_PER + j)));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_s[g] <= n_s[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_SQRT-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[LAT_SQRT-1];
    assign o_root = r_s[LAT_SQRT-1].res[31:0];
endmodule

FILE: src/pfp_udiv.sv
// Pipelined rounded divide (mag * 2^30 + root/2) / root, two quotient bits per stage (one in the last).
// Depends on pfp_pkg.
module pfp_udiv import pfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [30:0] i_mag,
    input  logic [31:0] i_root,
    output logic        o_vld,
    output logic [30:0] o_quo
);
    typedef struct packed {
        logic [61:0] rem;
        logic [30:0] quo;
        logic [31:0] root;
    } t_dv;

    function automatic t_dv dv_step(t_dv s, int pos);
        logic [62:0] sub;
        t_dv r;
        r   = s;
        sub = {31'd0, s.root} << pos;
        if ({1'b0, s.rem} >= sub) begin
            r.rem = s.rem - sub[61:0];
            r.quo = {s.quo[29:0], 1'b1};
        end else begin
            r.quo = {s.quo[29:0], 1'b0};
        end
        return r;
    endfunction

    logic [LAT_DIV-1:0] r_vld;
    t_dv r_d [LAT_DIV];
    t_dv n_d [LAT_DIV];
    logic [61:0] num;

    assign num = ({31'd0, i_mag} << 30) + 62'(i_root >> 1);

    for (genvar g = 0; g < LAT_DIV; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_comb begin
                n_d[g] = '{rem: num, quo: 31'd0, root: i_root};
                for (int j = 0; j < DIV_PER; j++) begin
                    if (g * DIV_PER + j < DIV_ITER) begin
                        n_d[g] = dv_step(n_d[g], DIV_ITER - 1 - (g * DIV_PER + j));
                    end
                end
            end
        end else begin : g_rest
            always_comb begin
                n_d[g] = r_d[g-1];
                for (int j = 0; j < DIV_PER; j++) begin
                    if (g * DIV_PER + j < DIV_ITER) begin
                        n_d[g] = dv_step(n_d[g], DIV_ITER - 1 - (g * DIV_PER + j));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_d[g] <= n_d[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_DIV-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[LAT_DIV-1];
    assign o_quo = r_d[LAT_DIV-1].quo;
endmodule

FILE: src/plane_from_three_points.sv
// Plane through three points: top level with the offset stages and alignment delays.
// Depends on pfp_pkg, pfp_cross, pfp_scale, pfp_isqrt, pfp_udiv and the macros header.
//
// Takes a request of three Q16.16 points A, B, C on i_points when start is
// high; busy never rises, so a new request is taken on every clock. Each
// request yields exactly one result, shown on o_result for one cycle with
// o_valid high. Results come out in request order and cannot be held off,
// so the receiver must take them as they appear. The result is the unit
// normal (Q2.30) of the plane and the offset d = -(n . A) in Q16.16,
// saturated to 32 bits. Collinear or coincident points set degenerate and
// zero every coefficient.
//
// Pipeline: three stages of edge differences and exact cross product, five
// stages that rescale the normal so its largest component sits in
// [2^30, 2^31) and sum the squares, sixteen stages of square root (two
// result bits per stage), sixteen stages of three parallel dividers (two
// quotient bits per stage, one in the last), and four stages for sign, the
// dot product with A, the sum and the final rounding and saturation. The
// square root and divider depths follow from the steps each stage takes.
`include "plane_from_three_points_macros.svh"

module plane_from_three_points import pfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_points i_points,
    output logic    busy,
    output logic    o_valid,
    output t_plane  o_result
);
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    // sign bits of the three components and the degenerate flag
    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_tag;

    logic   cross_vld;
    t_cross cross_res;
    logic   scale_vld;
    t_comp  scale_comp [3];
    logic [63:0] scale_q;
    logic   scale_deg;
    logic   sqrt_vld;
    logic [31:0] root;
    logic   div_vld [3];
    logic [30:0] quo [3];

    // hold A until the offset stages need it
    t_vec r_a_dly [LAT_FRONT];
    // hold the rescaled components across the square root
    t_comp r_comp_dly [LAT_SQRT][3];
    logic  r_deg_dly [LAT_SQRT];
    // hold signs and the flag across the divider
    t_tag  r_tag_dly [LAT_DIV];

    logic               r_x_vld, r_y_vld, r_z_vld, r_vld;
    logic signed [31:0] r_x_n [3];
    t_vec               r_x_a;
    logic               r_x_deg;
    logic signed [63:0] r_y_p [3];
    logic signed [31:0] r_y_n [3];
    logic               r_y_deg;
    logic signed [63:0] r_z_sum;
    logic signed [31:0] r_z_n [3];
    logic               r_z_deg;
    t_plane             r_out;
    t_plane             n_out;

    logic        sneg;
    logic [63:0] smag;
    logic [33:0] sm;

    // result checks used by the assertions
    logic        res_zero;
    logic        res_unit;

    assign busy = 1'b0;

    pfp_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_pts   (i_points),
        .o_vld   (cross_vld),
        .o_cross (cross_res)
    );

    pfp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cross_vld),
        .i_cross (cross_res),
        .o_vld   (scale_vld),
        .o_comp  (scale_comp),
        .o_q     (scale_q),
        .o_deg   (scale_deg)
    );

    pfp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (scale_vld),
        .i_val   (scale_q),
        .o_vld   (sqrt_vld),
        .o_root  (root)
    );

    for (genvar k = 0; k < 3; k++) begin : g_div
        pfp_udiv u_udiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sqrt_vld),
            .i_mag   (r_comp_dly[LAT_SQRT-1][k].mag),
            .i_root  (root),
            .o_vld   (div_vld[k]),
            .o_quo   (quo[k])
        );
    end

    // alignment delay lines: payload only, they advance every cycle
    always_ff @(posedge i_clk) begin
        r_a_dly[0] <= '{x: i_points.point_a_x, y: i_points.point_a_y,
                        z: i_points.point_a_z};
        for (int i = 1; i < LAT_FRONT; i++) begin
            r_a_dly[i] <= r_a_dly[i-1];
        end
        r_comp_dly[0] <= scale_comp;
        r_deg_dly[0]  <= scale_deg;
        for (int i = 1; i < LAT_SQRT; i++) begin
            r_comp_dly[i] <= r_comp_dly[i-1];
            r_deg_dly[i]  <= r_deg_dly[i-1];
        end
        r_tag_dly[0] <= '{neg: {r_comp_dly[LAT_SQRT-1][2].neg,
                                r_comp_dly[LAT_SQRT-1][1].neg,
                                r_comp_dly[LAT_SQRT-1][0].neg},
                          deg: r_deg_dly[LAT_SQRT-1]};
        for (int i = 1; i < LAT_DIV; i++) begin
            r_tag_dly[i] <= r_tag_dly[i-1];
        end
    end

    // offset: d = -(n . A), rounded half away from zero, saturated
    always_comb begin
        sneg = r_z_sum[63];
        smag = 64'(sneg ? -r_z_sum : r_z_sum);
        sm   = 34'((65'(smag) + 65'd536870912) >> 30);
        n_out.normal_x   = r_z_n[0];
        n_out.normal_y   = r_z_n[1];
        n_out.normal_z   = r_z_n[2];
        n_out.degenerate = 1'b0;
        if (sneg) begin
            if (sm > 34'd2147483647) n_out.offset = 32'sh7FFFFFFF;
            else                     n_out.offset = 32'(sm);
        end else begin
            if (sm > 34'd2147483648) n_out.offset = 32'sh80000000;
            else                     n_out.offset = 32'(-sm);
        end
        // drop all coefficients for collinear points
        if (r_z_deg) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
            r_y_vld <= 1'b0;
            r_z_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_x_vld <= div_vld[0];
            r_y_vld <= r_x_vld;
            r_z_vld <= r_y_vld;
            r_vld   <= r_z_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_x_n[k] <= r_tag_dly[LAT_DIV-1].neg[k] ? -$signed({1'b0, quo[k]})
                                                    :  $signed({1'b0, quo[k]});
            r_y_n[k] <= r_x_n[k];
            r_z_n[k] <= r_y_n[k];
        end
        r_x_a   <= r_a_dly[LAT_FRONT-1];
        r_x_deg <= r_tag_dly[LAT_DIV-1].deg;
        r_y_p[0] <= r_x_n[0] * r_x_a.x;
        r_y_p[1] <= r_x_n[1] * r_x_a.y;
        r_y_p[2] <= r_x_n[2] * r_x_a.z;
        r_y_deg  <= r_x_deg;
        r_z_sum  <= r_y_p[0] + r_y_p[1] + r_y_p[2];
        r_z_deg  <= r_y_deg;
        r_out    <= n_out;
    end

    assign o_valid  = r_vld;
    assign o_result = r_out;

    assign res_zero = (o_result.normal_x == 32'sd0) && (o_result.normal_y == 32'sd0)
                   && (o_result.normal_z == 32'sd0) && (o_result.offset == 32'sd0);
    assign res_unit = (o_result.normal_x <= 32'sd1073741824)
                   && (o_result.normal_x >= -32'sd1073741824)
                   && (o_result.normal_y <= 32'sd1073741824)
                   && (o_result.normal_y >= -32'sd1073741824)
                   && (o_result.normal_z <= 32'sd1073741824)
                   && (o_result.normal_z >= -32'sd1073741824);

    `PFP_ASSERT_IMPL(a_deg_zero, i_clk, i_rst_n, o_valid && o_result.degenerate, res_zero, "degenerate result with nonzero coefficients")
    `PFP_ASSERT_IMPL(a_unit_range, i_clk, i_rst_n, o_valid && !o_result.degenerate, res_unit, "normal component out of unit range")
    `PFP_ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_valid, $past(start, LAT_TOTAL), "result without a matching request")
    `PFP_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, (div_vld[0] == div_vld[1]) && (div_vld[0] == div_vld[2]), "dividers out of step")
    `PFP_ASSERT_NEXT(a_deg_flow, i_clk, i_rst_n, r_z_vld && r_z_deg, o_valid && o_result.degenerate, "degenerate flag lost in final stage")
endmodule
